// ===== src/bpe_pkg.sv =====
// bpe_pkg: shared types and constants for the battery percent estimator
`timescale 1ns / 1ps
`default_nettype none
package bpe_pkg;

	localparam int AVG_SAMPLES = 20;
	localparam int BURST_COUNT = 2;

	// reciprocal division: floor(n / d) = (n * ceil(2^DIV_SHIFT / d)) >> DIV_SHIFT for n < 2^19
	localparam int DIV_SHIFT   = 24;
	localparam int RECIP_W     = 25;
	localparam int AVG_RECIP   = ((2 ** DIV_SHIFT) + AVG_SAMPLES - 1) / AVG_SAMPLES;
	localparam int BURST_DIV   = BURST_COUNT - 1;
	localparam int BURST_RECIP = ((2 ** DIV_SHIFT) + BURST_DIV - 1) / BURST_DIV;

	// (v - 3150) * 100 / 1043 as one constant multiply and shift
	localparam int PCT_MUL_W  = 24;
	localparam int PCT_MUL    = 12868500;
	localparam int PCT_SHIFT  = 27;

	localparam int VOLT_W     = 13;
	localparam int PCT_W      = 7;
	localparam int PSUM_W     = 12;
	localparam int VSUM_W     = 19;
	localparam int COUNT_W    = 6;
	localparam int SHOWN_P_W  = 8;
	localparam int SHOWN_V_W  = 16;
	localparam int HYST_W     = 7;

	localparam logic [SHOWN_P_W-1:0] SHOWN_P_RESET = 8'd188;
	localparam logic [HYST_W-1:0]    HYST_RESET    = 7'd5;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_FIRST  = 2'd1,
		MODE_BURST  = 2'd2
	} run_mode_t;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_ARM    = 2'd1,
		OP_BURST  = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

endpackage
`default_nettype wire

// ===== src/battery_percent_estimator_core.sv =====
// battery_percent_estimator_core: sample runs, averaging and hysteresis display update
// an accepted input beat passes the input and result registers to its result beat
// throughput: one beat per cycle; s_axis_tready follows m_axis_tready through one
// input register and one result register
// reset: arst_n clears the run state to first reading, shown percent to 188,
// shown voltage to 0 and hysteresis_step to 5; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module battery_percent_estimator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // voltage_mv [12:0], zero pad
	input  wire logic [1:0]  s_axis_tuser,   // op [1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [23:0] m_axis_tdata,   // display_percent [7:0], mean_voltage_mv [23:8]
	output logic      [0:0]  m_axis_tuser,   // updated [0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  cfg_data        // hysteresis_step
);
	import bpe_pkg::*;

	localparam int PPROD_W = PSUM_W + RECIP_W;
	localparam int VPROD_W = VSUM_W + RECIP_W;

	logic                  valid_s1;
	op_t                   op_s1;
	logic [VOLT_W-1:0]     volt_s1;
	logic                  advance;

	logic [HYST_W-1:0]     hyst_q;
	run_mode_t             mode_q, mode_e, mode_d;
	logic [COUNT_W-1:0]    count_q, count_e, count_n, count_d;
	logic [PSUM_W-1:0]     psum_q, psum_d;
	logic [VSUM_W-1:0]     vsum_q, vsum_d;
	logic [SHOWN_P_W-1:0]  shown_p_q, shown_p_d;
	logic [SHOWN_V_W-1:0]  shown_v_q, shown_v_d;
	logic                  upd;

	logic [PCT_W-1:0]      pct;
	logic [PPROD_W-1:0]    avg_pprod, burst_pprod;
	logic [VPROD_W-1:0]    avg_vprod, burst_vprod;
	logic [PSUM_W-1:0]     avg_mean_p, burst_mean_p;
	logic [VSUM_W-1:0]     avg_mean_v, burst_mean_v;
	logic [PSUM_W-1:0]     shown_ext, hyst_ext;

	logic                  out_valid_q;
	logic [23:0]           out_data_q;
	logic                  out_upd_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_upd_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= op_t'(s_axis_tuser);
			volt_s1 <= s_axis_tdata[VOLT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_q <= HYST_RESET;
		end else if (cfg_valid) begin
			hyst_q <= cfg_data;
		end
	end

	bpe_pct_map u_pct_map (
		.voltage_mv (volt_s1),
		.percent    (pct)
	);

	// run means by reciprocal multiply
	assign avg_pprod    = PPROD_W'(psum_q) * PPROD_W'(AVG_RECIP);
	assign burst_pprod  = PPROD_W'(psum_q) * PPROD_W'(BURST_RECIP);
	assign avg_vprod    = VPROD_W'(vsum_q) * VPROD_W'(AVG_RECIP);
	assign burst_vprod  = VPROD_W'(vsum_q) * VPROD_W'(BURST_RECIP);
	assign avg_mean_p   = avg_pprod[DIV_SHIFT +: PSUM_W];
	assign burst_mean_p = burst_pprod[DIV_SHIFT +: PSUM_W];
	assign avg_mean_v   = avg_vprod[DIV_SHIFT +: VSUM_W];
	assign burst_mean_v = burst_vprod[DIV_SHIFT +: VSUM_W];
	assign shown_ext    = PSUM_W'(shown_p_q);
	assign hyst_ext     = PSUM_W'(hyst_q);

	always_comb begin
		mode_e    = mode_q;
		count_e   = count_q;
		mode_d    = mode_q;
		count_d   = count_q;
		psum_d    = psum_q;
		vsum_d    = vsum_q;
		shown_p_d = shown_p_q;
		shown_v_d = shown_v_q;
		upd       = 1'b0;
		count_n   = '0;
		if (op_s1 == OP_ARM) begin
			if (mode_q == MODE_NORMAL) begin
				mode_d  = MODE_FIRST;
				count_d = '0;
			end
		end else begin
			if (op_s1 == OP_BURST) begin
				mode_e = MODE_BURST;
				count_e = '0;
			end
			count_n = count_e + COUNT_W'(1);
			mode_d  = mode_e;
			count_d = count_n;
			if (mode_e == MODE_FIRST && count_n > COUNT_W'(2)) begin
				mode_d    = MODE_NORMAL;
				count_d   = '0;
				shown_p_d = psum_q[SHOWN_P_W-1:0];
				shown_v_d = vsum_q[SHOWN_V_W-1:0];
				upd       = 1'b1;
			end else if (mode_e == MODE_BURST && count_n > COUNT_W'(BURST_COUNT)) begin
				mode_d  = MODE_NORMAL;
				count_d = '0;
				if (burst_mean_p > shown_ext || shown_p_q > SHOWN_P_W'(100) ||
				    (burst_mean_p < shown_ext && shown_ext - burst_mean_p > hyst_ext)) begin
					shown_p_d = burst_mean_p[SHOWN_P_W-1:0];
					shown_v_d = burst_mean_v[SHOWN_V_W-1:0];
					upd       = 1'b1;
				end
			end else if (mode_e == MODE_NORMAL && count_n > COUNT_W'(AVG_SAMPLES + 1)) begin
				count_d = '0;
				if ((avg_mean_p > shown_ext && avg_mean_p - shown_ext > hyst_ext) ||
				    avg_mean_p < shown_ext) begin
					shown_p_d = avg_mean_p[SHOWN_P_W-1:0];
					shown_v_d = avg_mean_v[SHOWN_V_W-1:0];
					upd       = 1'b1;
				end
			end else if (count_n == COUNT_W'(1)) begin
				// first beat of a run only clears the sums
				psum_d = '0;
				vsum_d = '0;
			end else begin
				psum_d = psum_q + PSUM_W'(pct);
				vsum_d = vsum_q + VSUM_W'(volt_s1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_FIRST;
			count_q   <= '0;
			psum_q    <= '0;
			vsum_q    <= '0;
			shown_p_q <= SHOWN_P_RESET;
			shown_v_q <= '0;
		end else if (advance) begin
			mode_q    <= mode_d;
			count_q   <= count_d;
			psum_q    <= psum_d;
			vsum_q    <= vsum_d;
			shown_p_q <= shown_p_d;
			shown_v_q <= shown_v_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {shown_v_d, shown_p_d};
			out_upd_q  <= upd;
		end
	end

endmodule
`default_nettype wire

// ===== src/bpe_pct_map.sv =====
// bpe_pct_map: piecewise map of one voltage sample to a charge percent
`timescale 1ns / 1ps
`default_nettype none
module bpe_pct_map (
	input  wire logic [bpe_pkg::VOLT_W-1:0] voltage_mv,
	output logic      [bpe_pkg::PCT_W-1:0]  percent
);
	import bpe_pkg::*;

	logic [VOLT_W-1:0]             hi_diff;
	logic [VOLT_W-1:0]             mid_diff;
	logic [PCT_MUL_W+10-1:0]       mid_prod;

	assign hi_diff  = voltage_mv - VOLT_W'(3340);
	assign mid_diff = voltage_mv - VOLT_W'(3150);
	// mid band offset stays below 810, ten bits
	assign mid_prod = (PCT_MUL_W + 10)'(mid_diff[9:0]) * (PCT_MUL_W + 10)'(PCT_MUL);

	always_comb begin
		if (voltage_mv >= VOLT_W'(4100)) begin
			percent = PCT_W'(100);
		end else if (voltage_mv >= VOLT_W'(3960)) begin
			percent = hi_diff[3 +: PCT_W];
		end else if (voltage_mv >= VOLT_W'(3220)) begin
			percent = mid_prod[PCT_SHIFT +: PCT_W];
		end else if (voltage_mv >= VOLT_W'(3020)) begin
			percent = PCT_W'(5);
		end else begin
			percent = PCT_W'(1);
		end
	end

endmodule
`default_nettype wire
